// ===== sv/sobol_pkg.sv =====
// ----------------------------------------------------------------------------
// Sobol sampler package
// Shared constants, types and helpers for the Owen-scrambled Sobol sampler.
// ----------------------------------------------------------------------------
package sobol_pkg;

  localparam int unsigned Columns    = 52;
  localparam int unsigned Dimensions = 1024;
  localparam int unsigned Depth      = Columns * Dimensions;
  localparam int unsigned AddrW      = $clog2(Depth);
  localparam int unsigned BitW       = $clog2(Columns + 1);

  localparam logic [31:0] MixK0 = 32'h3d20adea;
  localparam logic [31:0] MixK1 = 32'h05526c56;
  localparam logic [31:0] MixK2 = 32'h53a22864;

  localparam logic ActWrite  = 1'b0;
  localparam logic ActSample = 1'b1;

  // Scramble row steps, one per cell
  localparam logic [2:0] StepMulK0 = 3'd0;
  localparam logic [2:0] StepSeed  = 3'd1;
  localparam logic [2:0] StepMulK1 = 3'd2;
  localparam logic [2:0] StepMulK2 = 3'd3;

  // Accumulator cell payload handed along the row
  typedef struct packed {
    logic        vld;
    logic [31:0] acc;
    logic [31:0] seed;
    logic        scr;
  } sob_tok_t;

  function automatic logic [31:0] flip32(input logic [31:0] x);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) r[i] = x[31-i];
    return r;
  endfunction

endpackage

// ===== sv/sobol_sample_owen_scrambled_top.sv =====
// ----------------------------------------------------------------------------
// Owen-scrambled Sobol sampler
// Column store, bit-serial XOR accumulation and a four-cell scramble row.
// ----------------------------------------------------------------------------
// Write item: one store write. Sample item: a store read per column (one column
// per cycle through the single store port), then the row entry register, the four
// cells and the output register. One sample at a time; the next input is taken
// only after the output transfer.
// Synchronous active-low reset clears control; the store is not cleared.
module sobol_sample_owen_scrambled_top import sobol_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: column_address[15:0], column_word[47:16], point_index[99:48],
  //        dimension_number[109:100], scramble_seed[141:110], scramble_on[142]
  input  logic [143:0] in_tdata,
  // tuser: action
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: sample_value
  output logic [31:0]  out_tdata
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_MIX, S_OUT} st_t;

  st_t              st_r, st_nxt;
  logic [BitW-1:0]  bit_r, bit_nxt;
  logic [51:0]      idx_r, idx_nxt;
  logic [16:0]      base_r, base_nxt;
  logic [31:0]      acc_r, acc_nxt, seed_r, seed_nxt;
  logic             scr_r, scr_nxt, rdv_r, rdv_nxt, take_r, take_nxt;
  logic [31:0]      out_r, out_nxt;
  logic             oval_r, oval_nxt, st_vld_r, st_vld_nxt;
  logic [2:0]       wait_r, wait_nxt;
  logic             we;
  logic [AddrW-1:0] ram_addr;
  logic [31:0]      rdata;
  logic [16:0]      rd_full;
  sob_tok_t         tok [5];

  assign in_tready = (st_r == S_IDLE) && !oval_r;
  assign we = in_tvalid && in_tready && (in_tuser == ActWrite)
              && ({1'b0, in_tdata[15:0]} < 17'(Depth));
  assign rd_full = base_r + 17'(bit_r);

  // Address the store: write on a load transfer, else read the next column
  always_comb begin
    if (st_r == S_READ) ram_addr = rd_full[AddrW-1:0];
    else                ram_addr = in_tdata[AddrW-1:0];
  end

  sobol_ram #(.Width(32), .Dep(Depth)) u_ram (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(in_tdata[47:16]), .rdata(rdata)
  );

  // Feed the scramble row, bit reversed on entry
  assign tok[0] = '{vld: st_vld_r, acc: flip32(acc_r), seed: seed_r, scr: scr_r};

  for (genvar g = 0; g < 4; g++) begin : g_row
    sobol_cell u_cell (
      .clk(clk), .rst_n(rst_n), .op(3'(g)), .tok_in(tok[g]), .tok_out(tok[g+1])
    );
  end

  // Sequence the column reads and the hand-off to the row
  always_comb begin
    st_nxt = st_r; bit_nxt = bit_r; idx_nxt = idx_r; base_nxt = base_r;
    acc_nxt = acc_r; seed_nxt = seed_r; scr_nxt = scr_r;
    rdv_nxt = 1'b0; take_nxt = 1'b0; out_nxt = out_r; oval_nxt = oval_r;
    st_vld_nxt = 1'b0; wait_nxt = wait_r;
    if (rdv_r && take_r) acc_nxt = acc_r ^ rdata;
    unique case (st_r)
      S_IDLE: begin
        if (in_tvalid && in_tready && in_tuser == ActSample) begin
          st_nxt = S_READ; bit_nxt = '0; acc_nxt = '0;
          idx_nxt = in_tdata[99:48];
          base_nxt = 17'(in_tdata[109:100] * 17'(Columns));
          seed_nxt = in_tdata[141:110]; scr_nxt = in_tdata[142];
        end
      end
      S_READ: begin
        if (bit_r == BitW'(Columns)) begin
          st_nxt = S_MIX; wait_nxt = '0;
        end else begin
          rdv_nxt = 1'b1;
          take_nxt = idx_r[bit_r[5:0]] && (rd_full < 17'(Depth));
          bit_nxt = bit_r + 1'b1;
        end
      end
      S_MIX: begin
        if (wait_r == 3'd0) st_vld_nxt = 1'b1;
        wait_nxt = wait_r + 1'b1;
        if (tok[4].vld) begin
          out_nxt = tok[4].scr ? flip32(tok[4].acc) : flip32(tok[4].acc);
          oval_nxt = 1'b1; st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!oval_r) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (oval_r && out_tready) oval_nxt = 1'b0;
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; oval_r <= 1'b0; rdv_r <= 1'b0; st_vld_r <= 1'b0;
    end else begin
      st_r <= st_nxt; oval_r <= oval_nxt; rdv_r <= rdv_nxt; st_vld_r <= st_vld_nxt;
    end
    bit_r <= bit_nxt; idx_r <= idx_nxt; base_r <= base_nxt; acc_r <= acc_nxt;
    seed_r <= seed_nxt; scr_r <= scr_nxt; take_r <= take_nxt; out_r <= out_nxt;
    wait_r <= wait_nxt;
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = out_r;

endmodule

// ===== sv/sobol_ram.sv =====
// ----------------------------------------------------------------------------
// Sobol generic RAM
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module sobol_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Dep   = 64
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [$clog2(Dep)-1:0] addr,
  input  logic [Width-1:0]       wdata,
  output logic [Width-1:0]       rdata
);

  logic [Width-1:0] mem [Dep];

  // Write or read one word per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/sobol_cell.sv =====
// ----------------------------------------------------------------------------
// Sobol mix cell
// One stage of the scramble row: applies one step when scrambling is on and hands on the token.
// ----------------------------------------------------------------------------
module sobol_cell import sobol_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic [2:0] op,
  input  sob_tok_t tok_in,
  output sob_tok_t tok_out
);

  sob_tok_t tok_r, tok_nxt;
  logic [31:0] mul_a, mul_b, prod;

  // Pick the operands of this stage's step
  always_comb begin
    mul_a = tok_in.acc;
    unique case (op)
      StepMulK0: mul_b = MixK0;
      StepSeed: begin
        // add the seed, then multiply by the odd upper half of the seed
        mul_a = tok_in.acc + tok_in.seed;
        mul_b = {16'h0, tok_in.seed[31:17], 1'b1};
      end
      StepMulK1: mul_b = MixK1;
      StepMulK2: mul_b = MixK2;
      default:   mul_b = 32'h1;
    endcase
    prod = mul_a * mul_b;
    tok_nxt = tok_in;
    if (tok_in.scr) begin
      unique case (op)
        StepMulK0: tok_nxt.acc = tok_in.acc ^ prod;
        StepSeed:  tok_nxt.acc = prod;
        StepMulK1: tok_nxt.acc = tok_in.acc ^ prod;
        StepMulK2: tok_nxt.acc = tok_in.acc ^ prod;
        default:   tok_nxt.acc = tok_in.acc;
      endcase
    end
  end

  // Hold the token for the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.acc  <= tok_nxt.acc;
    tok_r.seed <= tok_nxt.seed;
    tok_r.scr  <= tok_nxt.scr;
  end

  assign tok_out = tok_r;

endmodule

// ===== test/tb_sobol_sample_owen_scrambled_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Owen-scrambled Sobol sampler testbench
// Loads generator columns, requests samples with and without scrambling and
// compares every output transfer with a fixed expectation or a local prediction.
// ----------------------------------------------------------------------------
module tb_sobol_sample_owen_scrambled_top;
  import sobol_pkg::*;

  typedef struct {
    logic        act;
    logic [15:0] addr;
    logic [31:0] word;
    logic [51:0] idx;
    logic [9:0]  dim;
    logic [31:0] seed;
    logic        scr;
    logic        has_exp;
    logic [31:0] exp_val;
  } item_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;

  // local copy of the column store; written flags keep reads legal
  logic [31:0] columns_mem [Depth];
  bit          columns_set [Depth];
  logic [31:0] pending_samples [$];
  int          fail_count;
  bit          hold_off_req;
  item_t       directed_rows [$];

  sobol_sample_owen_scrambled_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] reverse_bits(logic [31:0] x);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) r[i] = x[31-i];
    return r;
  endfunction

  function automatic logic [31:0] owen_hash(logic [31:0] seed, logic [31:0] v);
    logic [31:0] t;
    t = reverse_bits(v);
    t = t ^ (t * MixK0);
    t = t + seed;
    t = t * ((seed >> 16) | 32'd1);
    t = t ^ (t * MixK1);
    t = t ^ (t * MixK2);
    return reverse_bits(t);
  endfunction

  function automatic logic [31:0] predict_sample(item_t it);
    logic [31:0] acc;
    int unsigned a;
    acc = '0;
    for (int b = 0; b < Columns; b++) begin
      a = it.dim * Columns + b;
      if (it.idx[b] && a < Depth) acc ^= columns_mem[a];
    end
    return it.scr ? owen_hash(it.seed, acc) : acc;
  endfunction

  // index with only written columns set (or zero columns out of range)
  function automatic logic [51:0] legal_index(logic [9:0] dim, logic [51:0] want);
    logic [51:0] r;
    r = want;
    for (int b = 0; b < Columns; b++)
      if (!columns_set[dim * Columns + b]) r[b] = 1'b0;
    return r;
  endfunction

  // Drive one item and update the predicted state on its transfer
  task automatic send_item(item_t it);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.act;
    in_tdata  <= {1'b0, it.scr, it.seed, it.dim, it.idx, it.word, it.addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (it.act == ActWrite) begin
      if (it.addr < Depth) begin
        columns_mem[it.addr] = it.word;
        columns_set[it.addr] = 1'b1;
      end
    end else begin
      pending_samples.push_back(it.has_exp ? it.exp_val : predict_sample(it));
    end
  endtask

  function automatic item_t write_row(logic [15:0] addr, logic [31:0] word);
    item_t it;
    it = '{default: '0};
    it.act = ActWrite; it.addr = addr; it.word = word;
    return it;
  endfunction

  function automatic item_t sample_row(logic [51:0] idx, logic [9:0] dim, logic [31:0] seed,
                                       logic scr);
    item_t it;
    it = '{default: '0};
    it.act = ActSample; it.idx = idx; it.dim = dim; it.seed = seed; it.scr = scr;
    it.addr = 16'($urandom); it.word = $urandom;
    return it;
  endfunction

  // Check each output transfer against the oldest prediction
  initial begin
    int stall;
    logic [31:0] exp_v;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      // hold off for a long stretch once, so the block fills and stalls
      if (hold_off_req) begin
        stall = 400;
        hold_off_req = 1'b0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample, expected none, actual %h", $time, out_tdata);
        fail_count++;
      end else begin
        exp_v = pending_samples.pop_front();
        if (out_tdata !== exp_v) begin
          $display("%0t: sample_value mismatch, expected %h, actual %h",
                   $time, exp_v, out_tdata);
          fail_count++;
        end
      end
    end
  end

  initial begin
    item_t it;
    logic [9:0] dm;
    logic [51:0] ix;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = ActWrite;
    fail_count = 0;
    hold_off_req = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: dimension 0 with single-bit and all-ones columns, extremes of the store
    directed_rows.push_back(write_row(16'd0, 32'h8000_0000));
    directed_rows.push_back(write_row(16'd1, 32'hffff_ffff));
    directed_rows.push_back(write_row(16'd51, 32'h0000_0001));
    directed_rows.push_back(write_row(16'(Depth - 1), 32'ha5a5_5a5a));
    directed_rows.push_back(write_row(16'(Depth - 52), 32'h1234_5678));
    directed_rows.push_back(write_row(16'hffff, 32'hdead_beef)); // out of range, ignored
    directed_rows.push_back(write_row(16'(Depth), 32'hdead_beef));
    it = sample_row(52'h0, 10'd0, 32'h0, 1'b0); it.has_exp = 1; it.exp_val = 32'h0;
    directed_rows.push_back(it);
    it = sample_row(52'h1, 10'd0, 32'h0, 1'b0); it.has_exp = 1; it.exp_val = 32'h8000_0000;
    directed_rows.push_back(it);
    it = sample_row(52'h3, 10'd0, 32'h0, 1'b0); it.has_exp = 1; it.exp_val = 32'h7fff_ffff;
    directed_rows.push_back(it);
    it = sample_row(52'h8_0000_0000_0003, 10'd0, 32'h0, 1'b0);
    it.has_exp = 1; it.exp_val = 32'h7fff_fffe;
    directed_rows.push_back(it);
    directed_rows.push_back(sample_row(52'h0, 10'd0, 32'hffff_ffff, 1'b1));
    directed_rows.push_back(sample_row(52'h3, 10'd0, 32'hffff_ffff, 1'b1));
    directed_rows.push_back(sample_row(52'h1, 10'd0, 32'h0, 1'b1));
    it = sample_row(52'h8_0000_0000_0000, 10'd1023, 32'h0, 1'b0);
    it.has_exp = 1; it.exp_val = 32'ha5a5_5a5a;
    directed_rows.push_back(it);
    directed_rows.push_back(sample_row(52'h1, 10'd1023, 32'h8001_7fff, 1'b1));
    foreach (directed_rows[i]) begin
      it = directed_rows[i];
      if (it.act == ActSample) it.idx = legal_index(it.dim, it.idx);
      send_item(it);
    end

    // random: write columns mostly in four dimensions first, then mostly samples
    for (int n = 0; n < 750; n++) begin
      if (n == 300) hold_off_req = 1'b1;
      // pause the sender until every expected result has come
      if (n == 500) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending_samples.size() == 0);
      end
      dm = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 3)) * 10'd341;
      if (n < 150 || $urandom_range(0, 4) == 0) begin
        it = write_row(16'(dm * Columns + $urandom_range(0, Columns - 1)), $urandom);
        if ($urandom_range(0, 20) == 0) it.addr = 16'($urandom_range(Depth, 16'hffff));
      end else begin
        ix = 52'({$urandom, $urandom});
        if ($urandom_range(0, 5) == 0) ix = '1;
        it = sample_row(legal_index(dm, ix), dm, $urandom, 1'($urandom));
      end
      send_item(it);
    end
    in_tvalid <= 1'b0;
    wait (pending_samples.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("** sobol_sample_owen_scrambled_top: PASSED **");
    else
      $display("** sobol_sample_owen_scrambled_top: FAILED **");
    $finish;
  end

  initial begin
    #20ms;
    $display("** sobol_sample_owen_scrambled_top: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
sv/sobol_pkg.sv
sv/sobol_ram.sv
sv/sobol_cell.sv
sv/sobol_sample_owen_scrambled_top.sv
test/tb_sobol_sample_owen_scrambled_top.sv
